// ----- design/lnc_pkg.sv -----
// Shared types and constants for the LRU name cache with cost counter.
// No dependencies; used by the interfaces, the cell and the top level.
package lnc_pkg;

  localparam int MAX_ENTRIES_DEF = 32;
  localparam int NAME_BYTES_DEF  = 20;
  localparam int NAME_BYTES_MAX  = 20;

  localparam int LOW_W  = 64;
  localparam int MID_W  = 64;
  localparam int HIGH_W = 32;
  localparam int FLAT_W = LOW_W + MID_W + HIGH_W;
  localparam int LEN_W  = 5;
  localparam int CAP_W  = 6;
  localparam int COST_W = 3;
  localparam int TOT_W  = 32;

  localparam logic [CAP_W-1:0]  CAP_RESET = 6'd32;
  localparam logic [COST_W-1:0] HIT_COST  = 3'd1;
  localparam logic [COST_W-1:0] MISS_COST = 3'd5;
  localparam logic [8:0]        CASE_GAP  = 9'd32;

  // Per-cell control broadcast from the top level.
  typedef struct packed {
    logic valid;   // cell holds an occupied slot and a request is taken
    logic wr_sel;  // load the presented name this cycle
    logic evict;   // miss on a full cache: every cell shifts down
  } lnc_cell_ctl_t;

endpackage

// ----- design/lnc_in_if.sv -----
// Request channel of the LRU name cache: valid/ready plus one name.
// Depends on lnc_pkg for field widths.
interface lnc_in_if;
  logic                         valid;
  logic                         ready;
  logic [lnc_pkg::LOW_W-1:0]    name_bytes_low;
  logic [lnc_pkg::MID_W-1:0]    name_bytes_mid;
  logic [lnc_pkg::HIGH_W-1:0]   name_bytes_high;
  logic [lnc_pkg::LEN_W-1:0]    name_length;

  modport source (output valid, name_bytes_low, name_bytes_mid, name_bytes_high,
                  name_length, input ready);
  modport sink   (input valid, name_bytes_low, name_bytes_mid, name_bytes_high,
                  name_length, output ready);
endinterface

// ----- design/lnc_out_if.sv -----
// Result channel of the LRU name cache: valid/ready plus hit and costs.
// Depends on lnc_pkg for field widths.
interface lnc_out_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic [lnc_pkg::COST_W-1:0]   access_cost;
  logic [lnc_pkg::TOT_W-1:0]    total_cost;

  modport source (output valid, hit, access_cost, total_cost, input ready);
  modport sink   (input valid, hit, access_cost, total_cost, output ready);
endinterface

// ----- design/lnc_cell.sv -----
// One slot of the recency chain: stores a name, compares it with the request
// and takes its upper neighbor's name when the chain shifts. Depends on lnc_pkg.
module lnc_cell #(
  parameter int NAME_BYTES = lnc_pkg::NAME_BYTES_DEF
) (
  input  logic                          clk,
  input  lnc_pkg::lnc_cell_ctl_t        ctl,
  input  logic [NAME_BYTES*8-1:0]       req_bytes,
  input  logic [lnc_pkg::LEN_W-1:0]     req_len,
  input  logic [NAME_BYTES*8-1:0]       nbr_bytes,
  input  logic [lnc_pkg::LEN_W-1:0]     nbr_len,
  input  logic                          chain_in,
  output logic                          chain_out,
  output logic [NAME_BYTES*8-1:0]       bytes_q,
  output logic [lnc_pkg::LEN_W-1:0]     len_q
);

  logic [NAME_BYTES*8-1:0]   bytes_r, bytes_nxt;
  logic [lnc_pkg::LEN_W-1:0] len_r, len_nxt;
  logic                      match;
  logic [NAME_BYTES-1:0]     byte_ok;

  // Byte pairs match when equal or exactly one case gap apart.
  always_comb begin
    logic [8:0] a;
    logic [8:0] b;
    for (int k = 0; k < NAME_BYTES; k++) begin
      a = {1'b0, bytes_r[k*8 +: 8]};
      b = {1'b0, req_bytes[k*8 +: 8]};
      byte_ok[k] = (lnc_pkg::LEN_W'(k) >= req_len) || (a == b) ||
                   (a == b + lnc_pkg::CASE_GAP) || (b == a + lnc_pkg::CASE_GAP);
    end
  end

  assign match     = ctl.valid && (len_r == req_len) && (&byte_ok);
  assign chain_out = chain_in | match;

  always_comb begin
    bytes_nxt = bytes_r;
    len_nxt   = len_r;
    if (ctl.wr_sel) begin
      bytes_nxt = req_bytes;
      len_nxt   = req_len;
    end else if (ctl.evict || chain_out) begin
      bytes_nxt = nbr_bytes;
      len_nxt   = nbr_len;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
    len_r   <= len_nxt;
  end

  assign bytes_q = bytes_r;
  assign len_q   = len_r;

endmodule

// ----- design/lru_name_cache_cost_counter.sv -----
// LRU name cache with saturating access cost counter, built as a chain of slot cells.
// An accepted request's result is loaded into the output register.
// Throughput: one request per cycle; all cells compare at once and shift in that cycle.
// The output register accepts a new request whenever it is empty or being drained.
// Reset (synchronous, active low): occupancy and cost total clear, capacity returns
// to 32, output empties; stored names are not cleared (slots above occupancy are unread).
module lru_name_cache_cost_counter #(
  parameter int MAX_ENTRIES = lnc_pkg::MAX_ENTRIES_DEF,
  parameter int NAME_BYTES  = lnc_pkg::NAME_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  lnc_in_if.sink                      in_chan,
  lnc_out_if.source                   out_chan,
  input  logic                        cfg_wr_en,
  input  logic [lnc_pkg::CAP_W-1:0]   cfg_wr_data
);

  localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CMP_W = (OCC_W > lnc_pkg::CAP_W) ? OCC_W : lnc_pkg::CAP_W;
  localparam int NB_W  = NAME_BYTES * 8;

  // Configuration and control state.
  logic [lnc_pkg::CAP_W-1:0]  cap_r;
  logic [OCC_W-1:0]           occ_r, occ_nxt;
  logic [lnc_pkg::TOT_W-1:0]  total_r, total_nxt;

  // Output register.
  logic                        out_valid_r;
  logic                        out_hit_r;
  logic [lnc_pkg::COST_W-1:0]  out_cost_r;

  logic                        accept;
  logic [lnc_pkg::FLAT_W-1:0]  req_flat;
  logic [NB_W-1:0]             req_bytes;
  logic [lnc_pkg::LEN_W-1:0]   req_len;
  logic [CMP_W-1:0]            occ_ext, cap_ext, cap_eff;
  logic                        hit;
  logic                        wr_en, evict;
  logic [OCC_W-1:0]            wr_idx;
  logic [lnc_pkg::COST_W-1:0]  cost;
  logic [lnc_pkg::TOT_W:0]     sum;

  logic [MAX_ENTRIES:0]        chain;
  logic [NB_W-1:0]             cell_bytes [MAX_ENTRIES];
  logic [lnc_pkg::LEN_W-1:0]   cell_len   [MAX_ENTRIES];
  lnc_pkg::lnc_cell_ctl_t      cell_ctl   [MAX_ENTRIES];

  // A new request enters when the result slot is free or being taken.
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  // Gather the name bytes and clamp the length to the slot size.
  assign req_flat  = {in_chan.name_bytes_high, in_chan.name_bytes_mid,
                      in_chan.name_bytes_low};
  assign req_bytes = req_flat[NB_W-1:0];
  assign req_len   = (in_chan.name_length > lnc_pkg::LEN_W'(NAME_BYTES)) ?
                     lnc_pkg::LEN_W'(NAME_BYTES) : in_chan.name_length;

  // Capacity above the cell count acts as a full row of cells.
  assign occ_ext = CMP_W'(occ_r);
  assign cap_ext = CMP_W'(cap_r);
  assign cap_eff = (cap_ext > CMP_W'(MAX_ENTRIES)) ? CMP_W'(MAX_ENTRIES) : cap_ext;

  // The chain carries "a match sits at or below this slot"; its end is the hit.
  assign chain[0] = 1'b0;
  assign hit      = chain[MAX_ENTRIES];

  // Decide where the presented name lands:
  //   hit: cells above the match shift down, name goes to the top occupied slot;
  //   miss with room: append above the occupied slots;
  //   miss on a full cache: drop the least recent slot, name goes on top;
  //   otherwise (zero capacity or capacity lowered below occupancy): store nothing.
  always_comb begin
    wr_en   = 1'b0;
    evict   = 1'b0;
    wr_idx  = occ_r - OCC_W'(1);
    occ_nxt = occ_r;
    if (accept) begin
      if (hit) begin
        wr_en = 1'b1;
      end else if (occ_ext < cap_eff) begin
        wr_en   = 1'b1;
        wr_idx  = occ_r;
        occ_nxt = occ_r + OCC_W'(1);
      end else if ((occ_ext == cap_eff) && (cap_eff != '0)) begin
        wr_en = 1'b1;
        evict = 1'b1;
      end
    end
  end

  // Saturating running cost.
  assign cost      = hit ? lnc_pkg::HIT_COST : lnc_pkg::MISS_COST;
  assign sum       = {1'b0, total_r} + (lnc_pkg::TOT_W + 1)'(cost);
  assign total_nxt = sum[lnc_pkg::TOT_W] ? {lnc_pkg::TOT_W{1'b1}} : sum[lnc_pkg::TOT_W-1:0];

  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    logic [NB_W-1:0]           nbr_bytes;
    logic [lnc_pkg::LEN_W-1:0] nbr_len;

    // The top cell has no upper neighbor; it only shifts when it is written
    // or unoccupied, so feed it the request.
    if (k == MAX_ENTRIES - 1) begin : g_top
      assign nbr_bytes = req_bytes;
      assign nbr_len   = req_len;
    end else begin : g_mid
      assign nbr_bytes = cell_bytes[k+1];
      assign nbr_len   = cell_len[k+1];
    end

    // Compare only on an accepted request, so a waiting or stale name never
    // shifts the chain.
    assign cell_ctl[k].valid  = accept && (OCC_W'(k) < occ_r);
    assign cell_ctl[k].wr_sel = wr_en && (wr_idx[IDX_W-1:0] == IDX_W'(k));
    assign cell_ctl[k].evict  = evict;

    lnc_cell #(
      .NAME_BYTES (NAME_BYTES)
    ) u_cell (
      .clk       (clk),
      .ctl       (cell_ctl[k]),
      .req_bytes (req_bytes),
      .req_len   (req_len),
      .nbr_bytes (nbr_bytes),
      .nbr_len   (nbr_len),
      .chain_in  (chain[k]),
      .chain_out (chain[k+1]),
      .bytes_q   (cell_bytes[k]),
      .len_q     (cell_len[k])
    );
  end

  // Control state: capacity, occupancy, cost total and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= lnc_pkg::CAP_RESET;
      occ_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      occ_r <= occ_nxt;
      if (accept) begin
        total_r     <= total_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: hold until the next accepted request.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_hit_r  <= hit;
      out_cost_r <= cost;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.hit         = out_hit_r;
  assign out_chan.access_cost = out_cost_r;
  assign out_chan.total_cost  = total_r;

endmodule

// ----- verif/tb_lru_name_cache_cost_counter.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the LRU name cache with its saturating cost counter.
// Depends on lnc_pkg, lnc_in_if, lnc_out_if and the lru_name_cache_cost_counter RTL.
module tb_lru_name_cache_cost_counter;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int HOLD_CYCLES = 60;

  // One presented name: bytes packed as {high, mid, low}, byte 0 lowest.
  typedef struct packed {
    logic [lnc_pkg::FLAT_W-1:0] bytes;
    logic [lnc_pkg::LEN_W-1:0]  len;
  } cache_name_t;

  // What one lookup must return.
  typedef struct packed {
    logic                       hit;
    logic [lnc_pkg::COST_W-1:0] cost;
    logic [lnc_pkg::TOT_W-1:0]  total;
  } lookup_outcome_t;

  // Mirror of the cache contents in recency order (slot 0 least recent), plus
  // the running cost and the capacity register. Each accepted request moves
  // the mirror forward and queues the outcome the block has to produce.
  class lru_cost_ledger;
    logic [lnc_pkg::FLAT_W-1:0] slot_bytes [lnc_pkg::MAX_ENTRIES_DEF];
    int unsigned                slot_len   [lnc_pkg::MAX_ENTRIES_DEF];
    int unsigned                occupancy;
    logic [lnc_pkg::TOT_W-1:0]  running_cost;
    logic [lnc_pkg::CAP_W-1:0]  capacity;
    lookup_outcome_t            awaited[$];
    int unsigned                faults;

    function new();
      occupancy    = 0;
      running_cost = '0;
      capacity     = lnc_pkg::CAP_RESET;
      faults       = 0;
    endfunction

    function void set_capacity(input logic [lnc_pkg::CAP_W-1:0] value);
      capacity = value;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // Bytes match when equal or exactly 32 apart as unsigned values.
    function bit same_name(input int unsigned s, input logic [lnc_pkg::FLAT_W-1:0] bytes,
                           input int unsigned len);
      int a;
      int b;
      if (slot_len[s] != len) return 1'b0;
      for (int k = 0; k < len; k++) begin
        a = int'(slot_bytes[s][8*k +: 8]);
        b = int'(bytes[8*k +: 8]);
        if (a != b && a - b != int'(lnc_pkg::CASE_GAP) && b - a != int'(lnc_pkg::CASE_GAP))
          return 1'b0;
      end
      return 1'b1;
    endfunction

    function void remove_slot(input int unsigned s);
      for (int unsigned k = s; k + 1 < occupancy; k++) begin
        slot_bytes[k] = slot_bytes[k+1];
        slot_len[k]   = slot_len[k+1];
      end
      occupancy--;
    endfunction

    function void append_slot(input logic [lnc_pkg::FLAT_W-1:0] bytes, input int unsigned len);
      if (occupancy >= lnc_pkg::MAX_ENTRIES_DEF) return;
      slot_bytes[occupancy] = bytes;
      slot_len[occupancy]   = len;
      occupancy++;
    endfunction

    function void note_lookup(input logic [lnc_pkg::LOW_W-1:0] lo,
                              input logic [lnc_pkg::MID_W-1:0] mid,
                              input logic [lnc_pkg::HIGH_W-1:0] hi,
                              input logic [lnc_pkg::LEN_W-1:0] raw_len);
      logic [lnc_pkg::FLAT_W-1:0] bytes;
      int unsigned                len;
      int unsigned                cap;
      int unsigned                s;
      int unsigned                found_at;
      bit                         found;
      lookup_outcome_t            o;
      bytes    = {hi, mid, lo};
      len      = (raw_len > lnc_pkg::NAME_BYTES_DEF) ? lnc_pkg::NAME_BYTES_DEF : raw_len;
      cap      = (capacity > lnc_pkg::MAX_ENTRIES_DEF) ? lnc_pkg::MAX_ENTRIES_DEF : capacity;
      found    = 1'b0;
      found_at = 0;
      for (s = 0; s < occupancy && !found; s++) begin
        if (same_name(s, bytes, len)) begin
          found    = 1'b1;
          found_at = s;
        end
      end
      if (found) begin
        remove_slot(found_at);
        append_slot(bytes, len);
      end else if (occupancy < cap) begin
        append_slot(bytes, len);
      end else if (occupancy == cap && cap > 0) begin
        remove_slot(0);
        append_slot(bytes, len);
      end
      o.hit  = found;
      o.cost = found ? lnc_pkg::HIT_COST : lnc_pkg::MISS_COST;
      if (running_cost > {lnc_pkg::TOT_W{1'b1}} - o.cost) running_cost = {lnc_pkg::TOT_W{1'b1}};
      else running_cost = running_cost + o.cost;
      o.total = running_cost;
      awaited.push_back(o);
    endfunction

    function void report(input string field, input logic [63:0] want, input logic [63:0] got);
      faults++;
      $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
    endfunction

    function void check_outcome(input logic hit, input logic [lnc_pkg::COST_W-1:0] cost,
                                input logic [lnc_pkg::TOT_W-1:0] total);
      lookup_outcome_t want;
      if (awaited.size() == 0) begin
        report("unrequested result, total_cost", '0, 64'(total));
        return;
      end
      want = awaited.pop_front();
      if (hit !== want.hit) report("hit", 64'(want.hit), 64'(hit));
      if (cost !== want.cost) report("access_cost", 64'(want.cost), 64'(cost));
      if (total !== want.total) report("total_cost", 64'(want.total), 64'(total));
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_wr_en;
  logic [lnc_pkg::CAP_W-1:0] cfg_wr_data;

  lnc_in_if  req_if();
  lnc_out_if rsp_if();

  lru_name_cache_cost_counter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (req_if),
    .out_chan   (rsp_if),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  lru_cost_ledger ledger;
  cache_name_t    name_pool [48];
  bit             sender_idling;
  bit             receiver_idling;
  bit             hold_request;
  int unsigned    cycle_count;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Watchdog: end a hung run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Sample both handshakes on the edge with pre-edge values. Requests are noted
  // before results are checked, so a request and its result never race.
  always @(posedge clk) begin
    if (rst_n && req_if.valid && req_if.ready)
      ledger.note_lookup(req_if.name_bytes_low, req_if.name_bytes_mid,
                         req_if.name_bytes_high, req_if.name_length);
    if (rst_n && rsp_if.valid && rsp_if.ready)
      ledger.check_outcome(rsp_if.hit, rsp_if.access_cost, rsp_if.total_cost);
  end

  // Result side: random stalls, plus one long hold-off on request. The hold
  // lets the one-deep output register fill so the block back-pressures input.
  initial begin
    int hold_left;
    bit hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (receiver_idling && $urandom_range(0, 99) < 16) begin
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  function automatic logic [lnc_pkg::FLAT_W-1:0] random_bytes();
    return {$urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  // All-ones over the first n bytes (n clamped to the name width).
  function automatic logic [lnc_pkg::FLAT_W-1:0] length_mask(input int n);
    return (lnc_pkg::FLAT_W'(1) << (8 * n)) - 1;
  endfunction

  function automatic cache_name_t filled(input logic [7:0] b,
                                         input logic [lnc_pkg::LEN_W-1:0] len);
    cache_name_t n;
    n.bytes = {(lnc_pkg::FLAT_W/8){b}};
    n.len   = len;
    return n;
  endfunction

  // Draw a name from the first span pool entries: mostly the pool name with
  // random case flips and junk past its length, some with one byte broken,
  // and the rest pure noise.
  function automatic cache_name_t draw_name(input int span);
    cache_name_t base;
    cache_name_t n;
    int          roll;
    int          eff;
    int          pos;
    roll = $urandom_range(0, 99);
    if (roll >= 88) begin
      n.bytes = random_bytes();
      n.len   = lnc_pkg::LEN_W'($urandom_range(0, 31));
      return n;
    end
    base  = name_pool[$urandom_range(0, span - 1)];
    n.len = (base.len >= lnc_pkg::NAME_BYTES_DEF) ?
            lnc_pkg::LEN_W'($urandom_range(lnc_pkg::NAME_BYTES_DEF, 31)) : base.len;
    eff   = (n.len > lnc_pkg::NAME_BYTES_DEF) ? lnc_pkg::NAME_BYTES_DEF : n.len;
    n.bytes = ((base.bytes ^ (random_bytes() & {(lnc_pkg::FLAT_W/8){8'h20}}))
               & length_mask(eff))
            | (random_bytes() & ~length_mask(eff));
    if (roll >= 75) begin
      if (eff == 0) begin
        n.len = lnc_pkg::LEN_W'(1);
      end else begin
        pos = $urandom_range(0, eff - 1);
        n.bytes[8*pos +: 8] = n.bytes[8*pos +: 8] ^ 8'($urandom_range(1, 255));
      end
    end
    return n;
  endfunction

  // Offer one request and hold it until the block takes it.
  task automatic send_name(input cache_name_t n);
    while (sender_idling && $urandom_range(0, 99) < 16) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid           <= 1'b1;
    req_if.name_bytes_low  <= n.bytes[lnc_pkg::LOW_W-1:0];
    req_if.name_bytes_mid  <= n.bytes[lnc_pkg::LOW_W +: lnc_pkg::MID_W];
    req_if.name_bytes_high <= n.bytes[lnc_pkg::LOW_W+lnc_pkg::MID_W +: lnc_pkg::HIGH_W];
    req_if.name_length     <= n.len;
    do @(posedge clk); while (!req_if.ready);
  endtask

  task automatic run_random(input int count, input int span);
    for (int i = 0; i < count; i++) send_name(draw_name(span));
  endtask

  // Drop valid and wait until every outstanding result has come back and the
  // output register is empty.
  task automatic drain_results();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (ledger.pending() != 0 || rsp_if.valid);
  endtask

  // Write capacity only with the block idle; one result per request, so after the drain
  // no request or result can still be in flight.
  task automatic write_capacity(input logic [lnc_pkg::CAP_W-1:0] value);
    drain_results();
    repeat (2) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    ledger.set_capacity(value);
  endtask

  initial begin
    cache_name_t probe;
    int          roll;
    ledger          = new();
    hold_request    = 1'b0;
    sender_idling   = 1'b1;
    receiver_idling = 1'b1;
    rst_n           <= 1'b0;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= '0;
    req_if.valid           <= 1'b0;
    req_if.name_bytes_low  <= '0;
    req_if.name_bytes_mid  <= '0;
    req_if.name_bytes_high <= '0;
    req_if.name_length     <= '0;

    // Pool of base names: mostly short, a few empty, a few full or overlong.
    foreach (name_pool[i]) begin
      roll = $urandom_range(0, 99);
      name_pool[i].bytes = random_bytes();
      if (roll < 10)
        name_pool[i].len = lnc_pkg::LEN_W'($urandom_range(lnc_pkg::NAME_BYTES_DEF, 31));
      else if (roll < 14)
        name_pool[i].len = '0;
      else
        name_pool[i].len = lnc_pkg::LEN_W'($urandom_range(1, lnc_pkg::NAME_BYTES_DEF - 1));
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Zero capacity from empty: every lookup misses and nothing is stored.
    write_capacity(6'd0);
    run_random(20, 8);

    // Single entry: after the first miss, every miss evicts.
    write_capacity(6'd1);
    run_random(40, 3);

    // Directed lookups on a three-entry cache.
    write_capacity(6'd3);
    send_name(filled(8'h00, 0));
    send_name(filled(8'hFF, 0));   // empty names always match
    send_name(filled(8'h41, 20));
    send_name(filled(8'h61, 20));  // case-folded hit at full width
    send_name(filled(8'h61, 31));  // overlong length clamps to full width
    send_name(filled(8'hFF, 20));
    send_name(filled(8'hFF, 31));
    send_name(filled(8'h00, 5));
    send_name(filled(8'h20, 5));   // gap of 32 on non-letters still matches
    send_name(filled(8'hC0, 5));
    send_name(filled(8'hE0, 5));
    send_name(filled(8'h40, 5));   // a gap of 32 from the stored 8'h20 name, so a hit
    send_name(filled(8'h10, 2));
    send_name(filled(8'hF0, 2));   // 8-bit wraparound is not a gap of 32
    probe.bytes        = random_bytes();
    probe.bytes[23:0]  = 24'h636261;
    probe.len          = 5'd3;
    send_name(probe);
    probe.bytes        = random_bytes();
    probe.bytes[23:0]  = 24'h434241;
    send_name(probe);              // junk past the length is ignored
    send_name(filled(8'h7A, 19));
    send_name(filled(8'h5A, 19));

    write_capacity(6'd8);
    run_random(100, 12);

    // Oversized capacity acts as the full size; no idling in this stretch.
    sender_idling   = 1'b0;
    receiver_idling = 1'b0;
    write_capacity(6'd63);
    run_random(150, 40);
    sender_idling   = 1'b1;
    receiver_idling = 1'b1;

    // Capacity below occupancy: misses store nothing, hits still reorder.
    write_capacity(6'd5);
    run_random(80, 40);

    // Back to full size, with one long receiver hold-off while requests keep
    // coming, and one sender pause until everything has drained.
    write_capacity(6'd32);
    run_random(40, 40);
    hold_request = 1'b1;
    run_random(50, 40);
    drain_results();
    run_random(70, 40);

    drain_results();
    repeat (5) @(posedge clk);
    if (ledger.faults == 0 && ledger.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/lnc_pkg.sv
design/lnc_in_if.sv
design/lnc_out_if.sv
design/lnc_cell.sv
design/lru_name_cache_cost_counter.sv
verif/tb_lru_name_cache_cost_counter.sv
